// File: sv/rlrf_pkg.sv
package rlrf_pkg;

	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChBang    = 8'h21;
	localparam logic [7:0] ChN       = 8'h4E;
	localparam logic [7:0] ChP       = 8'h50;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [2:0] PrefixLen = 3'd5;
	localparam logic [2:0] ShortLen  = 3'd4;

	typedef enum logic [2:0] {
		BK_SINGLE,
		BK_REFUSE,
		BK_RELEASE,
		BK_SHORT,
		BK_FULL
	} burst_kind_t;

	typedef struct packed {
		burst_kind_t kind;
		logic [2:0]  len;
		logic [7:0]  data;
		logic        to_client;
	} burst_t;

	function automatic logic [7:0] prefix_full_at(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h3F;
			3'd1: ch = 8'h52;
			3'd2: ch = 8'h4C;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] prefix_short_at(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h3F;
			2'd1: ch = 8'h52;
			2'd2: ch = 8'h4C;
			2'd3: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] burst_byte(input burst_t b, input logic [2:0] idx);
		logic [7:0] ch;
		case (b.kind)
			BK_SINGLE: ch = b.data;
			BK_REFUSE: ch = 8'h00;
			BK_RELEASE: ch = (idx == 3'(b.len - 3'd1)) ? b.data : prefix_full_at(idx);
			BK_SHORT: ch = prefix_short_at(idx[1:0]);
			BK_FULL: ch = prefix_full_at(idx);
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: sv/rlrf_core.sv
module rlrf_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  logic                 from_server_s1,
	input  logic [7:0]           byte_s1,
	input  logic [30:0]          rnd_s1,
	input  logic [30:0]          reply_rate_q,
	output rlrf_pkg::burst_t     burst,
	output logic                 burst_valid
);

	typedef enum logic [1:0] {
		PH_LISTEN = 2'd0,
		PH_DOWN   = 2'd1,
		PH_UP     = 2'd2,
		PH_SPARE  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		TRK_START = 3'd0,
		TRK_BANG  = 3'd1,
		TRK_CODE  = 3'd2,
		TRK_SPACE = 3'd3,
		TRK_OTHER = 3'd4
	} trk_t;

	phase_t     phase_q, phase_n, ph;
	trk_t       trk_q, trk_n;
	logic [2:0] mc_q, mc_n, mc, mc_inc;
	logic       side_ok;

	always_comb begin
		ph      = (phase_q == PH_SPARE) ? PH_LISTEN : phase_q;
		side_ok = ((ph == PH_UP) == from_server_s1);
		mc      = (mc_q < rlrf_pkg::PrefixLen) ? mc_q : 3'd0;
		mc_inc  = 3'(mc + 3'd1);
		phase_n = phase_q;
		trk_n   = trk_q;
		mc_n    = mc_q;
		burst.kind      = rlrf_pkg::BK_SINGLE;
		burst.len       = 3'd1;
		burst.data      = byte_s1;
		burst.to_client = 1'b0;
		if (!side_ok) begin
			burst.kind = rlrf_pkg::BK_REFUSE;
			burst.data = 8'h00;
		end else if (ph == PH_LISTEN) begin
			if (byte_s1 != rlrf_pkg::prefix_full_at(mc)) begin
				burst.kind = rlrf_pkg::BK_RELEASE;
				burst.len  = mc_inc;
				mc_n       = 3'd0;
				if (byte_s1 == rlrf_pkg::ChNewline) begin
					phase_n = PH_UP;
					trk_n   = TRK_START;
				end else begin
					phase_n = PH_DOWN;
				end
			end else if (mc_inc < rlrf_pkg::PrefixLen) begin
				burst.len = 3'd0;
				mc_n      = mc_inc;
				phase_n   = PH_LISTEN;
			end else begin
				if (rnd_s1 >= reply_rate_q) begin
					burst.kind = rlrf_pkg::BK_SHORT;
					burst.len  = rlrf_pkg::ShortLen;
				end else begin
					burst.kind = rlrf_pkg::BK_FULL;
					burst.len  = rlrf_pkg::PrefixLen;
				end
				mc_n    = 3'd0;
				phase_n = PH_DOWN;
			end
		end else if (ph == PH_DOWN) begin
			if (byte_s1 == rlrf_pkg::ChNewline) begin
				phase_n = PH_UP;
				trk_n   = TRK_START;
			end
		end else begin
			burst.to_client = 1'b1;
			case (trk_q)
				TRK_START: trk_n = (byte_s1 == rlrf_pkg::ChBang) ? TRK_BANG : TRK_OTHER;
				TRK_BANG: trk_n = (byte_s1 == rlrf_pkg::ChN || byte_s1 == rlrf_pkg::ChP)
					? TRK_CODE : TRK_OTHER;
				TRK_CODE: trk_n = (byte_s1 == rlrf_pkg::ChSpace) ? TRK_SPACE : TRK_OTHER;
				TRK_SPACE: begin
					if (byte_s1 == rlrf_pkg::ChNewline) begin
						trk_n   = TRK_START;
						phase_n = PH_LISTEN;
						mc_n    = 3'd0;
					end else begin
						trk_n = TRK_OTHER;
					end
				end
				default: trk_n = (byte_s1 == rlrf_pkg::ChNewline) ? TRK_START : TRK_OTHER;
			endcase
		end
		burst_valid = (burst.len != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LISTEN;
			trk_q   <= TRK_START;
			mc_q    <= 3'd0;
		end else if (commit) begin
			phase_q <= phase_n;
			trk_q   <= trk_n;
			mc_q    <= mc_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) mc_q < rlrf_pkg::PrefixLen)
		else $error("match count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) phase_q != PH_SPARE)
		else $error("unused phase reached");
	assert property (@(posedge clk) disable iff (!arst_n)
		mc_q != 3'd0 |-> phase_q == PH_LISTEN)
		else $error("held prefix outside listening");

endmodule

// File: sv/rlrf_emit.sv
module rlrf_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  rlrf_pkg::burst_t burst,
	input  logic             burst_valid,
	output logic             take,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             to_client,
	output logic             refused,
	output logic             last
);

	rlrf_pkg::burst_t burst_q;
	logic             busy_q;
	logic [2:0]       idx_q;

	assign last      = (idx_q == 3'(burst_q.len - 3'd1));
	assign take      = !busy_q || (out_ready && last);
	assign out_valid = busy_q;
	assign out_byte  = rlrf_pkg::burst_byte(burst_q, idx_q);
	assign to_client = burst_q.to_client;
	assign refused   = (burst_q.kind == rlrf_pkg::BK_REFUSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (take) begin
			busy_q <= burst_valid;
			idx_q  <= 3'd0;
		end else if (out_ready) begin
			idx_q <= 3'(idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && burst_valid) begin
			burst_q <= burst;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (burst_q.len != 3'd0 && idx_q < burst_q.len))
		else $error("beat index beyond burst");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && burst_q.kind == rlrf_pkg::BK_REFUSE |-> burst_q.len == 3'd1)
		else $error("refused burst longer than one beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_ready && !last |=> busy_q && idx_q == 3'($past(idx_q) + 3'd1))
		else $error("burst did not advance");

endmodule

// File: sv/request_line_rate_limit_filter.sv
// Accepted input is registered at s1, then in the emitter's burst register that
// drives the output. One input beat per cycle if each item yields at most one
// result and out_ready is high. An item with n results holds the output register
// for n beats (n up to 5), stalling input; a held prefix byte yields none.
// Reset: listening to client, no prefix held, reply line at start,
// reply_rate = 0x40000000, pipeline empty.
module request_line_rate_limit_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        from_server,
	input  logic [7:0]  byte_value,
	input  logic [30:0] random_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        to_client,
	output logic        refused,
	output logic        last
);

	logic             valid_s1, from_server_s1;
	logic [7:0]       byte_s1;
	logic [30:0]      rnd_s1;
	logic [30:0]      reply_rate_q;
	logic             take, commit, burst_valid;
	rlrf_pkg::burst_t burst;

	assign commit   = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			reply_rate_q <= 31'h4000_0000;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_we) begin
				reply_rate_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			from_server_s1 <= from_server;
			byte_s1        <= byte_value;
			rnd_s1         <= random_sample;
		end
	end

	rlrf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (commit),
		.from_server_s1 (from_server_s1),
		.byte_s1        (byte_s1),
		.rnd_s1         (rnd_s1),
		.reply_rate_q   (reply_rate_q),
		.burst          (burst),
		.burst_valid    (burst_valid)
	);

	rlrf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_valid (burst_valid && valid_s1),
		.take        (take),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.to_client   (to_client),
		.refused     (refused),
		.last        (last)
	);

endmodule
